// ----- rtl/lpc_pkg.sv -----
// Shared types and constants for the LRU page cache with per-process quota.
// No dependencies; used by lpc_scan and lru_page_cache_with_process_quota.
package lpc_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SLOT_W    = 4;

  localparam logic [CFG_W-1:0] EIU_RESET   = 5'd16;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd4;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRIES_IN_USE = 2'd0,
    CFG_PROC_LIMIT     = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_READ,
    ST_RDOUT
  } state_e;

  // scan unit control
  typedef struct packed {
    logic clear;
    logic en;
  } scan_ctrl_t;

  // scan unit findings
  typedef struct packed {
    logic match;
    logic free;
    logic own_lru;
    logic glob_lru;
  } scan_flags_t;

  // saturating timestamp increment
  function automatic logic [STAMP_W-1:0] stamp_inc(input logic [STAMP_W-1:0] s);
    stamp_inc = (s == {STAMP_W{1'b1}}) ? s : s + STAMP_W'(1);
  endfunction

endpackage

// ----- rtl/lpc_scan.sv -----
// Per-entry compare and accumulate unit for the page cache table scan.
// Finds first match, first free slot, owner count and owner/global LRU.
// Depends on lpc_pkg.
module lpc_scan #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned PID_WIDTH  = 16,
  parameter int unsigned PAGE_WIDTH = 16,
  localparam int unsigned IDXW = $clog2(ENTRIES),
  localparam int unsigned CNTW = $clog2(ENTRIES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpc_pkg::scan_ctrl_t         ctrl_i,
  input  logic [IDXW-1:0]             idx_i,
  input  logic                        entry_valid_i,
  input  logic [PID_WIDTH-1:0]        owner_i,
  input  logic [PAGE_WIDTH-1:0]       page_i,
  input  logic [lpc_pkg::STAMP_W-1:0] stamp_i,
  input  logic [PID_WIDTH-1:0]        req_pid_i,
  input  logic [PAGE_WIDTH-1:0]       req_page_i,
  output logic                        owner_eq_o,
  output lpc_pkg::scan_flags_t        flags_o,
  output logic [IDXW-1:0]             match_idx_o,
  output logic [IDXW-1:0]             free_idx_o,
  output logic [IDXW-1:0]             own_idx_o,
  output logic [IDXW-1:0]             glob_idx_o,
  output logic [CNTW-1:0]             own_cnt_o
);

  lpc_pkg::scan_flags_t        flags_q, flags_d;
  logic [IDXW-1:0]             match_idx_q, match_idx_d;
  logic [IDXW-1:0]             free_idx_q, free_idx_d;
  logic [IDXW-1:0]             own_idx_q, own_idx_d;
  logic [IDXW-1:0]             glob_idx_q, glob_idx_d;
  logic [lpc_pkg::STAMP_W-1:0] own_stamp_q, own_stamp_d;
  logic [lpc_pkg::STAMP_W-1:0] glob_stamp_q, glob_stamp_d;
  logic [CNTW-1:0]             own_cnt_q, own_cnt_d;
  logic                        owned;

  assign owner_eq_o = (owner_i == req_pid_i);
  assign owned      = entry_valid_i && owner_eq_o;

  always_comb begin
    flags_d      = flags_q;
    match_idx_d  = match_idx_q;
    free_idx_d   = free_idx_q;
    own_idx_d    = own_idx_q;
    glob_idx_d   = glob_idx_q;
    own_stamp_d  = own_stamp_q;
    glob_stamp_d = glob_stamp_q;
    own_cnt_d    = own_cnt_q;
    if (ctrl_i.clear) begin
      flags_d   = '0;
      own_cnt_d = '0;
    end else if (ctrl_i.en) begin
      if (owned && (page_i == req_page_i) && !flags_q.match) begin
        flags_d.match = 1'b1;
        match_idx_d   = idx_i;
      end
      if (owned) begin
        own_cnt_d = own_cnt_q + CNTW'(1);
        // strict less-than keeps the lowest index on ties
        if (!flags_q.own_lru || (stamp_i < own_stamp_q)) begin
          flags_d.own_lru = 1'b1;
          own_idx_d       = idx_i;
          own_stamp_d     = stamp_i;
        end
      end
      if (!entry_valid_i && !flags_q.free) begin
        flags_d.free = 1'b1;
        free_idx_d   = idx_i;
      end
      if (entry_valid_i && (!flags_q.glob_lru || (stamp_i < glob_stamp_q))) begin
        flags_d.glob_lru = 1'b1;
        glob_idx_d       = idx_i;
        glob_stamp_d     = stamp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      own_cnt_q <= '0;
    end else begin
      flags_q   <= flags_d;
      own_cnt_q <= own_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q  <= match_idx_d;
    free_idx_q   <= free_idx_d;
    own_idx_q    <= own_idx_d;
    glob_idx_q   <= glob_idx_d;
    own_stamp_q  <= own_stamp_d;
    glob_stamp_q <= glob_stamp_d;
  end

  assign flags_o     = flags_q;
  assign match_idx_o = match_idx_q;
  assign free_idx_o  = free_idx_q;
  assign own_idx_o   = own_idx_q;
  assign glob_idx_o  = glob_idx_q;
  assign own_cnt_o   = own_cnt_q;

endmodule

// ----- rtl/lru_page_cache_with_process_quota.sv -----
// Top level of the fully associative LRU page cache with per-process quota.
// Holds the tag/data/timestamp tables, the sequencer and the config registers.
// Depends on lpc_pkg and lpc_scan.

// A request is taken when start is high and busy is low. Lookup and write
// scan the enabled entries one per cycle through the single read port of the
// tables, feeding one shared compare unit (match, free slot, owner count,
// owner and global LRU). A lookup hit then reads the data in the READ and
// RDOUT states; flush scans all ENTRIES. Clear, and a lookup or write while
// the cache is disabled, finish without raising busy. The result appears
// for exactly one cycle with done_o high; the receiver cannot stall it, so
// it must take it then. A new request may be started in the cycle done_o is
// shown. Config writes are always ready and must only be issued while the
// block is idle. Table contents other than the valid bits are not cleared by
// reset.
module lru_page_cache_with_process_quota #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned DATA_WIDTH = 64,
  parameter int unsigned PID_WIDTH  = 16,
  parameter int unsigned PAGE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [lpc_pkg::OP_W-1:0]      op_i,
  input  logic [PID_WIDTH-1:0]          pid_i,
  input  logic [PAGE_WIDTH-1:0]         page_i,
  input  logic [DATA_WIDTH-1:0]         write_data_i,
  // result strobe and fields
  output logic                          done_o,
  output logic                          hit_o,
  output logic [DATA_WIDTH-1:0]         read_data_o,
  output logic [lpc_pkg::SLOT_W-1:0]    slot_o,
  output logic                          evicted_o,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lpc_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IDXW = $clog2(ENTRIES);
  localparam int unsigned CNTW = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CNTW > lpc_pkg::CFG_W) ? CNTW : lpc_pkg::CFG_W;
  localparam int unsigned SW   = lpc_pkg::STAMP_W;

  // ---------------- tables ----------------
  logic [PID_WIDTH-1:0]  owner_mem [ENTRIES];
  logic [PAGE_WIDTH-1:0] page_mem  [ENTRIES];
  logic [DATA_WIDTH-1:0] data_mem  [ENTRIES];
  logic [SW-1:0]         stamp_mem [ENTRIES];

  logic [ENTRIES-1:0]    valid_q, valid_d;

  logic [IDXW-1:0]       rd_addr;
  logic [PID_WIDTH-1:0]  owner_rd_q;
  logic [PAGE_WIDTH-1:0] page_rd_q;
  logic [DATA_WIDTH-1:0] data_rd_q;
  logic [SW-1:0]         stamp_rd_q;

  logic                  tag_we, data_we, stamp_we;
  logic [IDXW-1:0]       tag_waddr, data_waddr, stamp_waddr;
  logic [SW-1:0]         stamp_wdata;

  // ---------------- control state ----------------
  lpc_pkg::state_e       state_q, state_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic [CNTW-1:0]       len_q, len_d;
  logic                  cmp_en_q, cmp_en_d;
  logic [IDXW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [SW-1:0]         use_q, use_d;

  // latched request
  lpc_pkg::op_e          op_q;
  logic [PID_WIDTH-1:0]  pid_q;
  logic [PAGE_WIDTH-1:0] page_q;
  logic [DATA_WIDTH-1:0] wdata_q;

  // config registers
  logic [lpc_pkg::CFG_W-1:0] eiu_q, limit_q;

  // result registers
  logic                        done_q, out_ld;
  logic                        hit_q, out_hit;
  logic [DATA_WIDTH-1:0]       rdata_q, out_rdata;
  logic [lpc_pkg::SLOT_W-1:0]  slot_q;
  logic [IDXW-1:0]             out_slot;
  logic                        evict_q, out_evict;

  // scan unit
  lpc_pkg::scan_ctrl_t   scan_ctrl;
  lpc_pkg::scan_flags_t  flags;
  logic                  owner_eq;
  logic [IDXW-1:0]       match_idx, free_idx, own_idx, glob_idx;
  logic [CNTW-1:0]       own_cnt;

  // ---------------- derived values ----------------
  logic                  accept;
  lpc_pkg::op_e          op_in;
  logic [CMPW-1:0]       n_wide;
  logic [CNTW-1:0]       n_cnt;
  logic [lpc_pkg::CFG_W-1:0] limit_eff;
  logic                  at_quota;
  logic [IDXW-1:0]       fill_idx;
  logic                  scan_issue;
  logic                  scan_last;

  assign busy   = (state_q != lpc_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign op_in  = lpc_pkg::op_e'(op_i);

  // entries_in_use above ENTRIES acts as ENTRIES
  assign n_wide = (CMPW'(eiu_q) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(eiu_q);
  assign n_cnt  = n_wide[CNTW-1:0];

  // a limit of zero acts as one
  assign limit_eff = (limit_q == '0) ? lpc_pkg::CFG_W'(1) : limit_q;
  assign at_quota  = (CMPW'(own_cnt) >= CMPW'(limit_eff));

  // after evicting the owner's LRU entry the lowest free slot is the lower
  // of the old free slot and the victim; with no quota hit the cache is full
  // exactly when no free slot was seen, and the global LRU slot is refilled
  always_comb begin
    if (at_quota) begin
      fill_idx = (flags.free && (free_idx < own_idx)) ? free_idx : own_idx;
    end else begin
      fill_idx = flags.free ? free_idx : glob_idx;
    end
  end

  assign scan_last  = (cnt_q == len_q);
  assign scan_issue = (state_q == lpc_pkg::ST_SCAN) && !scan_last;

  lpc_scan #(
    .ENTRIES    (ENTRIES),
    .PID_WIDTH  (PID_WIDTH),
    .PAGE_WIDTH (PAGE_WIDTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (scan_ctrl),
    .idx_i         (cmp_idx_q),
    .entry_valid_i (valid_q[cmp_idx_q]),
    .owner_i       (owner_rd_q),
    .page_i        (page_rd_q),
    .stamp_i       (stamp_rd_q),
    .req_pid_i     (pid_q),
    .req_page_i    (page_q),
    .owner_eq_o    (owner_eq),
    .flags_o       (flags),
    .match_idx_o   (match_idx),
    .free_idx_o    (free_idx),
    .own_idx_o     (own_idx),
    .glob_idx_o    (glob_idx),
    .own_cnt_o     (own_cnt)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            lpc_pkg::OP_FLUSH: state_d = lpc_pkg::ST_SCAN;
            lpc_pkg::OP_CLEAR: state_d = lpc_pkg::ST_IDLE;
            default: state_d = (n_cnt == '0) ? lpc_pkg::ST_IDLE : lpc_pkg::ST_SCAN;
          endcase
        end
      end
      lpc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = (op_q == lpc_pkg::OP_FLUSH) ? lpc_pkg::ST_IDLE : lpc_pkg::ST_DECIDE;
        end
      end
      lpc_pkg::ST_DECIDE: begin
        if (flags.match && (op_q == lpc_pkg::OP_LOOKUP)) begin
          state_d = lpc_pkg::ST_READ;
        end else begin
          state_d = lpc_pkg::ST_IDLE;
        end
      end
      lpc_pkg::ST_READ:  state_d = lpc_pkg::ST_RDOUT;
      lpc_pkg::ST_RDOUT: state_d = lpc_pkg::ST_IDLE;
      default:           state_d = lpc_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    cnt_d       = cnt_q;
    len_d       = len_q;
    cmp_en_d    = 1'b0;
    cmp_idx_d   = cnt_q[IDXW-1:0];
    use_d       = use_q;
    valid_d     = valid_q;
    rd_addr     = cnt_q[IDXW-1:0];
    scan_ctrl   = '{clear: 1'b0, en: 1'b0};
    tag_we      = 1'b0;
    data_we     = 1'b0;
    stamp_we    = 1'b0;
    tag_waddr   = fill_idx;
    data_waddr  = fill_idx;
    stamp_waddr = fill_idx;
    stamp_wdata = lpc_pkg::stamp_inc(use_q);
    out_ld      = 1'b0;
    out_hit     = 1'b0;
    out_rdata   = '0;
    out_slot    = '0;
    out_evict   = 1'b0;

    unique case (state_q)
      lpc_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_d           = '0;
          scan_ctrl.clear = 1'b1;
          unique case (op_in)
            lpc_pkg::OP_FLUSH: len_d = CNTW'(ENTRIES);
            lpc_pkg::OP_CLEAR: begin
              valid_d = '0;
              out_ld  = 1'b1;
            end
            default: begin
              len_d  = n_cnt;
              // disabled cache answers all zero at once
              out_ld = (n_cnt == '0);
            end
          endcase
        end
      end
      lpc_pkg::ST_SCAN: begin
        scan_ctrl.en = cmp_en_q;
        if (scan_issue) begin
          cnt_d    = cnt_q + CNTW'(1);
          cmp_en_d = 1'b1;
        end
        if (cmp_en_q && (op_q == lpc_pkg::OP_FLUSH) && owner_eq) begin
          valid_d[cmp_idx_q] = 1'b0;
        end
        if (scan_last && (op_q == lpc_pkg::OP_FLUSH)) begin
          out_ld = 1'b1;
        end
      end
      lpc_pkg::ST_DECIDE: begin
        if (flags.match) begin
          use_d       = lpc_pkg::stamp_inc(use_q);
          stamp_we    = 1'b1;
          stamp_waddr = match_idx;
          if (op_q == lpc_pkg::OP_WRITE) begin
            data_we    = 1'b1;
            data_waddr = match_idx;
            out_ld     = 1'b1;
            out_hit    = 1'b1;
            out_slot   = match_idx;
          end
        end else if (op_q == lpc_pkg::OP_WRITE) begin
          // write miss: drop the victim, if any, then fill
          if (at_quota) begin
            valid_d[own_idx] = 1'b0;
          end else if (!flags.free) begin
            valid_d[glob_idx] = 1'b0;
          end
          valid_d[fill_idx] = 1'b1;
          use_d     = lpc_pkg::stamp_inc(use_q);
          tag_we    = 1'b1;
          data_we   = 1'b1;
          stamp_we  = 1'b1;
          out_ld    = 1'b1;
          out_slot  = fill_idx;
          out_evict = at_quota || !flags.free;
        end else begin
          out_ld = 1'b1;
        end
      end
      lpc_pkg::ST_READ: begin
        rd_addr = match_idx;
      end
      lpc_pkg::ST_RDOUT: begin
        out_ld    = 1'b1;
        out_hit   = 1'b1;
        out_rdata = data_rd_q;
        out_slot  = match_idx;
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lpc_pkg::ST_IDLE;
      cnt_q    <= '0;
      len_q    <= '0;
      cmp_en_q <= 1'b0;
      use_q    <= '0;
      valid_q  <= '0;
      done_q   <= 1'b0;
      eiu_q    <= lpc_pkg::EIU_RESET;
      limit_q  <= lpc_pkg::LIMIT_RESET;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      cmp_en_q <= cmp_en_d;
      use_q    <= use_d;
      valid_q  <= valid_d;
      done_q   <= out_ld;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (lpc_pkg::cfg_idx_e'(cfg_index_i))
          lpc_pkg::CFG_ENTRIES_IN_USE: eiu_q   <= cfg_data_i;
          lpc_pkg::CFG_PROC_LIMIT:     limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    if (accept) begin
      op_q    <= op_in;
      pid_q   <= pid_i;
      page_q  <= page_i;
      wdata_q <= write_data_i;
    end
    if (out_ld) begin
      hit_q   <= out_hit;
      rdata_q <= out_rdata;
      slot_q  <= lpc_pkg::SLOT_W'(out_slot);
      evict_q <= out_evict;
    end
  end

  // table read port, registered
  always_ff @(posedge clk_i) begin
    owner_rd_q <= owner_mem[rd_addr];
    page_rd_q  <= page_mem[rd_addr];
    data_rd_q  <= data_mem[rd_addr];
    stamp_rd_q <= stamp_mem[rd_addr];
  end

  // table write ports
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      owner_mem[tag_waddr] <= pid_q;
      page_mem[tag_waddr]  <= page_q;
    end
    if (data_we) begin
      data_mem[data_waddr] <= wdata_q;
    end
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign read_data_o = rdata_q;
  assign slot_o      = slot_q;
  assign evicted_o   = evict_q;

  // ---------------- assertions ----------------
  // a result only follows an accepted request or work in progress
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a request");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction in one result");

  // read data is zero unless the request hit
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (read_data_o == '0))
    else $error("read data on a miss");

  // the use counter never goes backward
  a_use_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (use_q >= $past(use_q)))
    else $error("use counter decreased");

endmodule
